>>> design/tola_pkg.sv
package tola_pkg;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic       op;
		logic [2:0] requester;
	} in_t;

	typedef struct packed {
		logic [15:0] ticket;
		logic        grant_valid;
		logic [2:0]  grant_id;
		logic        overflow;
		logic        bad_id;
	} out_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAX   = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_MIN   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic clear;
		logic rvalid;
		logic mode_min;
	} scan_ctrl_t;

endpackage

>>> design/tola_ram.sv
module tola_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tola_scan.sv
module tola_scan #(
	parameter int TICKET_BITS = 16,
	parameter int AW          = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tola_pkg::scan_ctrl_t    ctrl,
	input  logic [TICKET_BITS-1:0]  data,
	input  logic [AW-1:0]           idx,
	output logic [TICKET_BITS-1:0]  max_ticket,
	output logic                    have,
	output logic [AW-1:0]           best_id
);

	logic [TICKET_BITS-1:0] mx_q;
	logic [TICKET_BITS-1:0] best_q;
	logic [AW-1:0]          best_id_q;
	logic                   have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_q      <= '0;
			best_q    <= '0;
			best_id_q <= '0;
			have_q    <= 1'b0;
		end else if (ctrl.clear) begin
			mx_q      <= '0;
			best_q    <= '0;
			best_id_q <= '0;
			have_q    <= 1'b0;
		end else if (ctrl.rvalid) begin
			if (ctrl.mode_min) begin
				// ascending ids, so strict compare keeps the lower id on a tie
				if (data != '0 && (!have_q || data < best_q)) begin
					have_q    <= 1'b1;
					best_q    <= data;
					best_id_q <= idx;
				end
			end else if (data > mx_q) begin
				mx_q <= data;
			end
		end
	end

	assign max_ticket = mx_q;
	assign have       = have_q;
	assign best_id    = best_id_q;

endmodule

>>> design/ticket_order_lock_arbiter_unit.sv
// A request walks the first n entries of the ticket RAM (n the effective count) for the
// largest ticket, writes its new ticket, walks them again for the holder and loads the result;
// a release writes zero and then walks for the holder, an ignored id only walks for the holder.
// One item is handled at a time, the serial walks of the ticket RAM setting the pace; the next
// item is taken while a result waits. Reset: asynchronous, active low; all tickets read as
// zero through per-entry valid bits, active_q returns to 8.
module ticket_order_lock_arbiter_unit #(
	parameter int NUM_REQUESTERS = 8,
	parameter int TICKET_BITS    = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tola_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tola_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata
);

	localparam int AW    = $clog2(NUM_REQUESTERS);
	localparam int CNT_W = $clog2(NUM_REQUESTERS + 1);
	localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

	tola_pkg::state_t state_q;
	logic [3:0]             active_q;
	logic [CNT_W-1:0]       eff;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   op_q;
	logic [2:0]             id_q;
	logic                   bad_q;
	logic [TICKET_BITS-1:0] given_q;
	logic                   ovf_q;
	logic [NUM_REQUESTERS-1:0] valid_q;

	logic                   rv_s1;
	logic                   rvld_s1;
	logic [AW-1:0]          ridx_s1;

	logic                   issue;
	logic                   scan_done;
	logic                   in_fire;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [TICKET_BITS-1:0] ram_wdata;
	logic [TICKET_BITS-1:0] ram_rdata;
	logic [TICKET_BITS-1:0] rd_ticket;
	logic [TICKET_BITS-1:0] max_ticket;
	logic [TICKET_BITS-1:0] given;
	logic                   have;
	logic [AW-1:0]          best_id;
	logic                   out_valid_q;
	tola_pkg::out_t         out_q;
	tola_pkg::scan_ctrl_t   sctrl;

	always_comb begin
		if (int'(active_q) > NUM_REQUESTERS) begin
			eff = CNT_W'(NUM_REQUESTERS);
		end else begin
			eff = CNT_W'(active_q);
		end
	end

	assign in_ready  = (state_q == tola_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign issue     = (state_q == tola_pkg::ST_MAX || state_q == tola_pkg::ST_MIN)
		&& (idx_q < n_q);
	assign scan_done = (idx_q >= n_q) && !rv_s1;
	assign given     = (max_ticket == TICKET_TOP) ? TICKET_TOP
		: max_ticket + TICKET_BITS'(1);

	assign ram_we    = (state_q == tola_pkg::ST_WRITE);
	assign ram_waddr = AW'(id_q);
	assign ram_wdata = (op_q == tola_pkg::OP_REQUEST) ? given : '0;
	assign rd_ticket = rvld_s1 ? ram_rdata : '0;

	assign sctrl.clear    = in_fire || (state_q == tola_pkg::ST_WRITE);
	assign sctrl.rvalid   = rv_s1;
	assign sctrl.mode_min = (state_q == tola_pkg::ST_MIN);

	tola_ram #(
		.WIDTH(TICKET_BITS),
		.DEPTH(NUM_REQUESTERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	tola_scan #(
		.TICKET_BITS(TICKET_BITS),
		.AW         (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sctrl),
		.data       (rd_ticket),
		.idx        (ridx_s1),
		.max_ticket (max_ticket),
		.have       (have),
		.best_id    (best_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd8;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1   <= 1'b0;
			valid_q <= '0;
		end else begin
			rv_s1 <= issue;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rvld_s1 <= valid_q[idx_q[AW-1:0]];
			ridx_s1 <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tola_pkg::ST_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tola_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			unique case (state_q)
				tola_pkg::ST_IDLE: begin
					if (in_fire) begin
						n_q   <= eff;
						idx_q <= '0;
						if (int'(in_data.requester) >= int'(eff)) begin
							state_q <= tola_pkg::ST_MIN;
						end else if (in_data.op == tola_pkg::OP_REQUEST) begin
							state_q <= tola_pkg::ST_MAX;
						end else begin
							state_q <= tola_pkg::ST_WRITE;
						end
					end
				end
				tola_pkg::ST_MAX: begin
					if (scan_done) begin
						state_q <= tola_pkg::ST_WRITE;
					end
				end
				tola_pkg::ST_WRITE: begin
					idx_q   <= '0;
					state_q <= tola_pkg::ST_MIN;
				end
				tola_pkg::ST_MIN: begin
					if (scan_done) begin
						state_q <= tola_pkg::ST_DONE;
					end
				end
				tola_pkg::ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= tola_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tola_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= in_data.op;
			id_q    <= in_data.requester;
			bad_q   <= int'(in_data.requester) >= int'(eff);
			given_q <= '0;
			ovf_q   <= 1'b0;
		end
		if (state_q == tola_pkg::ST_WRITE && op_q == tola_pkg::OP_REQUEST) begin
			given_q <= given;
			ovf_q   <= (max_ticket == TICKET_TOP);
		end
		if (state_q == tola_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			out_q.ticket      <= 16'(given_q);
			out_q.grant_valid <= have;
			out_q.grant_id    <= have ? 3'(best_id) : 3'd0;
			out_q.overflow    <= ovf_q;
			out_q.bad_id      <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> design/tola_checker.sv
module tola_checker #(
	parameter int TICKET_BITS = 16
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tola_pkg::out_t out_data
);

	localparam logic [15:0] TICKET_CAP = 16'((64'd1 << TICKET_BITS) - 64'd1);

	a_in_taken: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed before transfer");

	a_no_grant_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.grant_valid |-> out_data.grant_id == 3'd0)
		else $error("grant id without a holder");

	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_id |-> out_data.ticket == 16'd0 && !out_data.overflow)
		else $error("ignored input gave a ticket");

	a_ovf_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.ticket == TICKET_CAP
			&& out_data.grant_valid)
		else $error("saturated ticket not at top value");

endmodule

bind ticket_order_lock_arbiter_unit tola_checker #(
	.TICKET_BITS(TICKET_BITS)
) u_tola_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/tb_ticket_order_lock_arbiter_unit.sv
module tb_ticket_order_lock_arbiter_unit;

	typedef struct {
		bit             do_cfg;
		logic [3:0]     cfg_val;
		tola_pkg::in_t  item;
		bit             typed;
		tola_pkg::out_t want;
	} lock_case_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	tola_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	tola_pkg::out_t out_data;
	logic           cfg_we;
	logic [3:0]     cfg_wdata;

	logic [15:0]    held_tkt [8];
	logic [3:0]     cur_count;
	tola_pkg::out_t grant_due [$];
	lock_case_t     dir_rows [$];
	bit             gaps_on;
	bit             hold_armed;
	int             fail_count;
	int             shown;

	ticket_order_lock_arbiter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic tola_pkg::out_t bakery_step(tola_pkg::in_t item);
		tola_pkg::out_t r;
		int             n;
		int             i;
		logic [15:0]    top_seen;
		logic [15:0]    low;
		bit             found;
		r = '0;
		n = (cur_count > 4'd8) ? 8 : int'(cur_count);
		if (item.requester >= n) begin
			r.bad_id = 1'b1;
		end else if (item.op == tola_pkg::OP_REQUEST) begin
			top_seen = '0;
			for (i = 0; i < n; i++)
				if (held_tkt[i] > top_seen)
					top_seen = held_tkt[i];
			if (top_seen == 16'hFFFF) begin
				r.ticket   = 16'hFFFF;
				r.overflow = 1'b1;
			end else begin
				r.ticket = top_seen + 16'd1;
			end
			held_tkt[item.requester] = r.ticket;
		end else begin
			held_tkt[item.requester] = '0;
		end
		found = 1'b0;
		low   = '0;
		for (i = 0; i < n; i++) begin
			if (held_tkt[i] != 0 && (!found || held_tkt[i] < low)) begin
				found      = 1'b1;
				low        = held_tkt[i];
				r.grant_id = i[2:0];
			end
		end
		r.grant_valid = found;
		return r;
	endfunction

	function automatic lock_case_t mk_row(bit do_cfg, logic [3:0] cv, logic op,
			logic [2:0] req, bit typed, tola_pkg::out_t want);
		lock_case_t c;
		c.do_cfg  = do_cfg;
		c.cfg_val = cv;
		c.item    = {op, req};
		c.typed   = typed;
		c.want    = want;
		return c;
	endfunction

	// entered and left at a falling edge; valid stays high after the transfer
	task automatic offer_item(input tola_pkg::in_t item, input bit typed,
			input tola_pkg::out_t want);
		tola_pkg::out_t calc;
		while (gaps_on && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		calc = bakery_step(item);
		grant_due.push_back(typed ? want : calc);
		in_data  <= item;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (grant_due.size() != 0);
	endtask

	task automatic set_count(input logic [3:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_count  = v;
	endtask

	// receiver side
	initial begin
		int hold_left;
		bit hold_done;
		out_ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 99) < 10) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		tola_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_due.size() == 0) begin
				fail_count++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result transfer: ticket=%0d grant=%0b/%0d ovf=%0b bad=%0b",
						out_data.ticket, out_data.grant_valid, out_data.grant_id,
						out_data.overflow, out_data.bad_id);
				end
			end else begin
				want = grant_due.pop_front();
				if (out_data !== want) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("mismatch: exp ticket=%0d grant=%0b/%0d ovf=%0b bad=%0b",
							want.ticket, want.grant_valid, want.grant_id,
							want.overflow, want.bad_id);
						$display("          got ticket=%0d grant=%0b/%0d ovf=%0b bad=%0b",
							out_data.ticket, out_data.grant_valid, out_data.grant_id,
							out_data.overflow, out_data.bad_id);
					end
				end
			end
		end
	end

	initial begin
		int            k;
		int            n;
		int            roll;
		tola_pkg::in_t item;
		logic [3:0]    pick;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = 4'd0;
		gaps_on    = 1'b1;
		hold_armed = 1'b0;
		fail_count = 0;
		shown      = 0;
		foreach (held_tkt[i])
			held_tkt[i] = '0;
		cur_count = 4'd8;

		// after reset, re-request, release without ticket, count 0 / 1 / 2 / 9 / 15,
		// hidden tickets under a shrunken count, tie going to the lower id
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 0, 1,
			tola_pkg::out_t'{16'd0, 1'b0, 3'd0, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 7, 1,
			tola_pkg::out_t'{16'd1, 1'b1, 3'd7, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 0, 1,
			tola_pkg::out_t'{16'd2, 1'b1, 3'd7, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 3, 1,
			tola_pkg::out_t'{16'd3, 1'b1, 3'd7, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 7, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 0, 0, '0));
		dir_rows.push_back(mk_row(1, 2, tola_pkg::OP_REQUEST, 3, 1,
			tola_pkg::out_t'{16'd0, 1'b0, 3'd0, 1'b0, 1'b1}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 1, 0, '0));
		dir_rows.push_back(mk_row(1, 0, tola_pkg::OP_REQUEST, 0, 1,
			tola_pkg::out_t'{16'd0, 1'b0, 3'd0, 1'b0, 1'b1}));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 7, 1,
			tola_pkg::out_t'{16'd0, 1'b0, 3'd0, 1'b0, 1'b1}));
		dir_rows.push_back(mk_row(1, 15, tola_pkg::OP_REQUEST, 5, 0, '0));
		dir_rows.push_back(mk_row(1, 9, tola_pkg::OP_RELEASE, 1, 0, '0));
		dir_rows.push_back(mk_row(1, 1, tola_pkg::OP_REQUEST, 0, 0, '0));
		dir_rows.push_back(mk_row(1, 3, tola_pkg::OP_REQUEST, 1, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 2, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 0, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 1, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 2, 0, '0));
		dir_rows.push_back(mk_row(1, 8, tola_pkg::OP_RELEASE, 3, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_REQUEST, 6, 0, '0));
		dir_rows.push_back(mk_row(0, 0, tola_pkg::OP_RELEASE, 0, 0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].do_cfg)
				set_count(dir_rows[i].cfg_val);
			offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end

		// climb one requester to the top ticket, then saturate; no idling here
		gaps_on <= 1'b0;
		set_count(4'd1);
		while (held_tkt[0] != 16'hFFFF)
			offer_item({tola_pkg::OP_REQUEST, 3'd0}, 0, '0);
		offer_item({tola_pkg::OP_REQUEST, 3'd0}, 0, '0);
		offer_item({tola_pkg::OP_REQUEST, 3'd5}, 0, '0);
		set_count(4'd2);
		offer_item({tola_pkg::OP_REQUEST, 3'd1}, 0, '0);
		set_count(4'd8);
		offer_item({tola_pkg::OP_REQUEST, 3'd3}, 0, '0);
		offer_item({tola_pkg::OP_RELEASE, 3'd0}, 0, '0);
		offer_item({tola_pkg::OP_RELEASE, 3'd1}, 0, '0);
		offer_item({tola_pkg::OP_RELEASE, 3'd3}, 0, '0);
		gaps_on <= 1'b1;

		for (k = 0; k < 700; k++) begin
			if (k % 90 == 89) begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					pick = 4'd0;
				else if (roll == 1)
					pick = 4'($urandom_range(9, 15));
				else if (roll < 4)
					pick = 4'd8;
				else
					pick = 4'($urandom_range(1, 8));
				set_count(pick);
			end
			if (k == 200)
				hold_armed <= 1'b1;
			if (k == 450)
				drain_results();
			n = (cur_count > 4'd8) ? 8 : int'(cur_count);
			item.op = ($urandom_range(0, 99) < 55) ? tola_pkg::OP_REQUEST
				: tola_pkg::OP_RELEASE;
			if (n > 0 && $urandom_range(0, 99) < 85)
				item.requester = 3'($urandom_range(0, n - 1));
			else
				item.requester = 3'($urandom_range(0, 7));
			offer_item(item, 0, '0);
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
